// ===== hw/rtl/integer_square_root_core_macros.svh =====
// Assertion helpers for the square root core.
`ifndef INTEGER_SQUARE_ROOT_CORE_MACROS_SVH
`define INTEGER_SQUARE_ROOT_CORE_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every rising clock edge outside reset
`define ISQRT_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// cond must never be seen outside reset
`define ISQRT_ASSERT_NEVER(label, clk, rstn, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`else

`define ISQRT_ASSERT(label, clk, rstn, prop, msg)
`define ISQRT_ASSERT_NEVER(label, clk, rstn, cond, msg)

`endif

`endif

// ===== hw/rtl/isqrt_pkg.sv =====
package isqrt_pkg;

  localparam int unsigned OperandW = 31;
  localparam int unsigned RootW    = 16;

  typedef logic [OperandW-1:0] operand_t;
  typedef logic [RootW-1:0]    root_t;

endpackage

// ===== hw/rtl/isqrt_operand_if.sv =====
interface isqrt_operand_if import isqrt_pkg::*; ();

  logic     valid;
  logic     ready;
  operand_t operand;

  modport source (output valid, output operand, input ready);
  modport sink   (input valid, input operand, output ready);

endinterface

// ===== hw/rtl/isqrt_root_if.sv =====
interface isqrt_root_if import isqrt_pkg::*; ();

  logic  valid;
  logic  ready;
  root_t root;

  modport source (output valid, output root, input ready);
  modport sink   (input valid, input root, output ready);

endinterface

// ===== hw/rtl/integer_square_root_core.sv =====
// Floor square root, one result bit per pipeline stage (restoring, remainder form).
// Each accepted word moves through the stage registers in order until its result is valid.
// Throughput: one word per cycle; the whole pipe holds while a result waits on ready.
// Reset: rst_ni (async, active low) clears the stage valid bits only; data regs keep
// whatever they hold and are ignored until refilled.
`include "integer_square_root_core_macros.svh"

module integer_square_root_core import isqrt_pkg::*; #(
  parameter int unsigned OPERAND_BITS = 31
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  isqrt_operand_if.sink   operand_i,
  isqrt_root_if.source    root_o
);

  localparam int unsigned Steps = (OPERAND_BITS + 1) / 2;
  localparam int unsigned ValW  = 2 * Steps;
  localparam int unsigned RootB = Steps;
  localparam int unsigned RemW  = RootB + 2;
  localparam int unsigned CurW  = RemW + 2;
  localparam int unsigned Last  = Steps - 1;
  localparam int unsigned KeepW = (OPERAND_BITS < OperandW) ? OPERAND_BITS : OperandW;

  logic [ValW-1:0]  value_in;
  logic [Steps-1:0] valid_q;
  logic [ValW-1:0]  value_q [Steps];
  logic [RemW-1:0]  rem_q   [Steps];
  logic [RootB-1:0] root_q  [Steps];
  logic             adv;

  // masked operand, zero extended to whole bit pairs
  assign value_in = ValW'(operand_i.operand[KeepW-1:0]);

  assign adv             = !valid_q[Last] || root_o.ready;
  assign operand_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= Steps'({valid_q, operand_i.valid});
    end
  end

  for (genvar s = 0; s < Steps; s++) begin : g_stage
    logic [ValW-1:0]  val_d;
    logic [RemW-1:0]  rem_in;
    logic [RootB-1:0] root_in;
    logic [1:0]       pair;
    logic [CurW-1:0]  cur;
    logic [CurW-1:0]  trial;
    logic             ge;
    logic [RemW-1:0]  rem_d;
    logic [RootB-1:0] root_d;

    if (s == 0) begin : g_first
      assign val_d   = value_in;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign val_d   = value_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
    end

    assign pair  = val_d[2*(Steps-1-s) +: 2];
    assign cur   = {rem_in, pair};
    assign trial = CurW'({root_in, 2'b01});
    assign ge    = cur >= trial;
    // remainder stays at most twice the root, so it fits RemW
    assign rem_d  = ge ? RemW'(cur - trial) : RemW'(cur);
    assign root_d = RootB'({root_in, ge});

    always_ff @(posedge clk_i) begin
      if (adv) begin
        value_q[s] <= val_d;
        rem_q[s]   <= rem_d;
        root_q[s]  <= root_d;
      end
    end
  end

  assign root_o.valid = valid_q[Last];
  assign root_o.root  = root_t'({{RootW{1'b0}}, root_q[Last]});

  // ---------------------------------------------------------------------------
  // checks
  logic [2*ValW-1:0] chk_sq;
  logic [2*ValW-1:0] chk_sq1;
  logic [2*ValW-1:0] chk_val;
  logic [2*ValW-1:0] chk_rem;

  assign chk_val = (2*ValW)'(value_q[Last]);
  assign chk_rem = (2*ValW)'(rem_q[Last]);
  assign chk_sq  = (2*ValW)'(root_q[Last]) * (2*ValW)'(root_q[Last]);
  assign chk_sq1 = ((2*ValW)'(root_q[Last]) + 1'b1) * ((2*ValW)'(root_q[Last]) + 1'b1);

  `ISQRT_ASSERT(a_root_low, clk_i, rst_ni, valid_q[Last] |-> chk_sq <= chk_val, "root squared exceeds operand")
  `ISQRT_ASSERT(a_root_high, clk_i, rst_ni, valid_q[Last] |-> chk_sq1 > chk_val, "root is too small")
  `ISQRT_ASSERT(a_rem_match, clk_i, rst_ni, valid_q[Last] |-> chk_sq + chk_rem == chk_val, "remainder out of step with root")
  `ISQRT_ASSERT(a_accept_fill, clk_i, rst_ni, (operand_i.valid && operand_i.ready) |=> valid_q[0], "accepted word not captured in first stage")

endmodule
